// ----- sv/mthcp_pkg.sv -----
// Package for the map token height/colour parser.
// Holds the transfer payload types, the parse phase codes and character helpers.
// No dependencies.
package mthcp_pkg;

  // Width of the parse phase register.
  localparam int unsigned PHASE_W = 3;

  // Parse phase codes.
  localparam logic [PHASE_W-1:0] PH_SPACE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEC        = 3'd1;
  localparam logic [PHASE_W-1:0] PH_COMMA      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ZERO       = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HEX        = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HEX_DIGITS = 3'd5;

  // Character codes that steer the parse.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_F = 8'd102;
  localparam logic [7:0] CH_X     = 8'd120;

  // One character of a token.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  // One parsed token.
  typedef struct packed {
    logic signed [31:0] height;
    logic [31:0]        color;
    logic               has_color;
    logic               bad_token;
  } result_t;

  // Hex digit decode: valid flag in the top bit, value in the low four bits.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // True for space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // True for a decimal digit.
  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decodes a hex digit of either case.
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      h.valid = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      h.valid = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
      h.valid = 1'b1;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

// ----- sv/map_token_height_color_parser_unit.sv -----
// Map token height/colour parser, top level.
// Path: a final character passes the input register, then loads the result register.
// Throughput: one character per cycle unless stalled; parse state updates once per character.
// Reset (synchronous, active high) empties both registers and returns the parse to whitespace.
// A full result register that is stalled holds back only a final character.
module map_token_height_color_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  mthcp_pkg::char_t    char_data,
  output logic                result_valid,
  input  logic                result_stall,
  output mthcp_pkg::result_t  result_data
);

  logic                held_valid;
  mthcp_pkg::char_t    held_data;
  logic                take;
  mthcp_pkg::result_t  result;

  // A character moves on unless it is final and the result register cannot load.
  assign take = held_valid && (!held_data.last_char || !result_valid || !result_stall);

  mthcp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .take       (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  mthcp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .held_data (held_data),
    .result    (result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && held_data.last_char) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take && held_data.last_char) begin
      result_data <= result;
    end
  end

endmodule

// ----- sv/mthcp_in_reg.sv -----
// Input register of the map token parser.
// Captures one character transfer and holds it until the parser takes it.
// Depends on mthcp_pkg.
module mthcp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  mthcp_pkg::char_t   char_data,
  input  logic               take,
  output logic               held_valid,
  output mthcp_pkg::char_t   held_data
);

  // The register may load when it is empty or its character leaves this cycle.
  assign char_stall = held_valid && !take;

  // Valid flag: cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      held_data <= char_data;
    end
  end

endmodule

// ----- sv/mthcp_parser.sv -----
// Parse state and per-character update of the map token parser.
// Advances the phase and accumulators by one character and forms the token result.
// Depends on mthcp_pkg.
module mthcp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  mthcp_pkg::char_t    held_data,
  output mthcp_pkg::result_t  result
);

  logic [mthcp_pkg::PHASE_W-1:0] parse_phase, parse_phase_next;
  logic                          negative, negative_next;
  logic [31:0]                   dec_accum, dec_accum_next;
  logic [31:0]                   hex_accum, hex_accum_next;
  logic                          error_seen, error_seen_next;

  logic [7:0]             c;
  logic [31:0]            dec_times_ten;
  logic [31:0]            digit;
  mthcp_pkg::hex_digit_t  hex;
  logic                   bad;
  logic                   col;

  assign c = held_data.char_code;

  // The height accumulates with its sign already applied, so no negation is needed at the end.
  assign dec_times_ten = {dec_accum[28:0], 3'b000} + {dec_accum[30:0], 1'b0};
  assign digit         = {24'd0, c - mthcp_pkg::CH_ZERO};
  assign hex           = mthcp_pkg::hex_value(c);

  // One character step of the parse.
  always_comb begin
    parse_phase_next = parse_phase;
    negative_next    = negative;
    dec_accum_next   = dec_accum;
    hex_accum_next   = hex_accum;
    error_seen_next  = error_seen;
    if (!error_seen) begin
      unique case (parse_phase)
        mthcp_pkg::PH_SPACE, mthcp_pkg::PH_DEC: begin
          if (parse_phase == mthcp_pkg::PH_SPACE && mthcp_pkg::is_space(c)) begin
            parse_phase_next = mthcp_pkg::PH_SPACE;
          end else if (parse_phase == mthcp_pkg::PH_SPACE &&
                       (c == mthcp_pkg::CH_PLUS || c == mthcp_pkg::CH_MINUS)) begin
            negative_next    = (c == mthcp_pkg::CH_MINUS);
            parse_phase_next = mthcp_pkg::PH_DEC;
          end else if (c == mthcp_pkg::CH_COMMA) begin
            parse_phase_next = mthcp_pkg::PH_COMMA;
          end else if (mthcp_pkg::is_dec(c)) begin
            parse_phase_next = mthcp_pkg::PH_DEC;
            dec_accum_next   = negative ? (dec_times_ten - digit) : (dec_times_ten + digit);
          end else begin
            parse_phase_next = mthcp_pkg::PH_DEC;
            error_seen_next  = 1'b1;
          end
        end
        mthcp_pkg::PH_COMMA: begin
          if (c == mthcp_pkg::CH_ZERO) begin
            parse_phase_next = mthcp_pkg::PH_ZERO;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        mthcp_pkg::PH_ZERO: begin
          if (c == mthcp_pkg::CH_X) begin
            parse_phase_next = mthcp_pkg::PH_HEX;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        mthcp_pkg::PH_HEX, mthcp_pkg::PH_HEX_DIGITS: begin
          if (hex.valid) begin
            hex_accum_next   = {hex_accum[27:0], hex.value};
            parse_phase_next = mthcp_pkg::PH_HEX_DIGITS;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        default: begin
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // Token result, meaningful on the final character.
  always_comb begin
    bad = error_seen_next || parse_phase_next == mthcp_pkg::PH_COMMA ||
          parse_phase_next == mthcp_pkg::PH_ZERO || parse_phase_next == mthcp_pkg::PH_HEX;
    col = !bad && (parse_phase_next == mthcp_pkg::PH_HEX_DIGITS);
    result.height    = bad ? 32'sd0 : $signed(dec_accum_next);
    result.color     = col ? hex_accum_next : 32'd0;
    result.has_color = col;
    result.bad_token = bad;
  end

  // State registers: cleared by reset and after every final character.
  always_ff @(posedge clk) begin
    if (rst || (take && held_data.last_char)) begin
      parse_phase <= mthcp_pkg::PH_SPACE;
      negative    <= 1'b0;
      dec_accum   <= '0;
      hex_accum   <= '0;
      error_seen  <= 1'b0;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      negative    <= negative_next;
      dec_accum   <= dec_accum_next;
      hex_accum   <= hex_accum_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for the map token height/colour parser.
// Feeds token characters with random gaps and result stalls, predicts each token's result
// and compares it field by field. Depends on mthcp_pkg and map_token_height_color_parser_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_q_t[$];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  mthcp_pkg::char_t   char_data = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  mthcp_pkg::result_t result_data;

  // Predicted parse state of the token in flight.
  logic [mthcp_pkg::PHASE_W-1:0] tok_phase = mthcp_pkg::PH_SPACE;
  logic                          tok_neg = 1'b0;
  logic [31:0]                   tok_dec = '0;
  logic [31:0]                   tok_hex = '0;
  logic                          tok_err = 1'b0;

  mthcp_pkg::result_t token_results_q[$];
  int                 error_count = 0;
  int                 live_chars = 0;
  bit                 idle_on = 1'b1;

  always #5 clk = ~clk;

  map_token_height_color_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Returns the parse state to the start of a token.
  task automatic clear_token();
    tok_phase = mthcp_pkg::PH_SPACE;
    tok_neg   = 1'b0;
    tok_dec   = '0;
    tok_hex   = '0;
    tok_err   = 1'b0;
  endtask

  // Advances the predicted parse by one character and, on the final one, queues the result.
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic               dec_now;
    logic               nib_ok;
    logic [3:0]         nib;
    logic               broken;
    mthcp_pkg::result_t r;
    dec_now = 1'b0;
    nib_ok  = 1'b0;
    nib     = '0;
    r       = '0;
    if (!tok_err) begin
      case (tok_phase)
        mthcp_pkg::PH_SPACE: begin
          if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
            // Leading whitespace is skipped.
          end else if (c == mthcp_pkg::CH_PLUS || c == mthcp_pkg::CH_MINUS) begin
            tok_neg   = (c == mthcp_pkg::CH_MINUS);
            tok_phase = mthcp_pkg::PH_DEC;
          end else begin
            tok_phase = mthcp_pkg::PH_DEC;
            dec_now   = 1'b1;
          end
        end
        mthcp_pkg::PH_DEC: dec_now = 1'b1;
        mthcp_pkg::PH_COMMA: begin
          if (c == mthcp_pkg::CH_ZERO) tok_phase = mthcp_pkg::PH_ZERO;
          else tok_err = 1'b1;
        end
        mthcp_pkg::PH_ZERO: begin
          if (c == mthcp_pkg::CH_X) tok_phase = mthcp_pkg::PH_HEX;
          else tok_err = 1'b1;
        end
        mthcp_pkg::PH_HEX, mthcp_pkg::PH_HEX_DIGITS: begin
          if (c >= 8'd48 && c <= 8'd57) begin
            nib_ok = 1'b1;
            nib    = 4'(c - 8'd48);
          end else if (c >= 8'd65 && c <= 8'd70) begin
            nib_ok = 1'b1;
            nib    = 4'(c - 8'd55);
          end else if (c >= 8'd97 && c <= 8'd102) begin
            nib_ok = 1'b1;
            nib    = 4'(c - 8'd87);
          end
          if (nib_ok) begin
            tok_hex   = {tok_hex[27:0], nib};
            tok_phase = mthcp_pkg::PH_HEX_DIGITS;
          end else begin
            tok_err = 1'b1;
          end
        end
        default: tok_err = 1'b1;
      endcase
      // Decimal part: digits accumulate, a comma opens the colour.
      if (dec_now) begin
        if (c == mthcp_pkg::CH_COMMA) tok_phase = mthcp_pkg::PH_COMMA;
        else if (c >= 8'd48 && c <= 8'd57) tok_dec = tok_dec * 32'd10 + 32'(c - 8'd48);
        else tok_err = 1'b1;
      end
    end
    if (last) begin
      broken = tok_err || tok_phase == mthcp_pkg::PH_COMMA ||
               tok_phase == mthcp_pkg::PH_ZERO || tok_phase == mthcp_pkg::PH_HEX;
      if (broken) begin
        r.bad_token = 1'b1;
      end else begin
        r.height    = tok_neg ? (32'd0 - tok_dec) : tok_dec;
        r.has_color = (tok_phase == mthcp_pkg::PH_HEX_DIGITS);
        r.color     = r.has_color ? tok_hex : 32'd0;
      end
      token_results_q.push_back(r);
      clear_token();
    end
  endtask

  // Sends one character, with a random gap first when idling is on.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{char_code: c, last_char: last};
    do @(posedge clk); while (char_stall);
    live_chars++;
    parse_char(c, last);
  endtask

  task automatic send_token(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    char_q_t q;
    q = {};
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_token(q);
  endtask

  // Largest and smallest heights, wrap-around, full and overflowing colours, extreme codes.
  task automatic test_extremes();
    send_text("0");
    send_text("2147483647");
    send_text("-2147483648");
    send_text("+4294967296");
    send_text("99999999999");
    send_text("-0,0xFFFFFFFF");
    send_text("1,0xabcdef09");
    send_text("7,0x123456789");
    send_token({8'd255});
    send_token({8'd53, 8'd0});
    send_token({8'd49, 8'd128, 8'd50});
  endtask

  // Bad digits, a second sign, a missing 0x and empty or broken hex parts.
  task automatic test_malformed();
    send_text("12a");
    send_text("+-1");
    send_text("1,1x");
    send_text("1,0X5");
    send_text("1,0xg");
    send_text("1,0x");
    send_text("1,");
    send_text("1,0");
    send_text("1,0x1g");
  endtask

  // Tokens without decimal digits: whitespace only, a bare sign, a colour straight away.
  task automatic test_empty_height();
    send_token({8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13});
    send_text("-");
    send_text(",0x5");
    send_token({8'd9, 8'd45, mthcp_pkg::CH_COMMA, mthcp_pkg::CH_ZERO, mthcp_pkg::CH_X, 8'd66});
  endtask

  // Builds a random token: mostly well formed, sometimes damaged or pure noise.
  task automatic build_token(output char_q_t q);
    int k;
    int pos;
    q = {};
    repeat ($urandom_range(0, 3)) begin
      k = $urandom_range(0, 5);
      q.push_back((k == 0) ? 8'd32 : 8'(8 + k));
    end
    k = $urandom_range(0, 3);
    if (k == 1) q.push_back(mthcp_pkg::CH_PLUS);
    else if (k == 2) q.push_back(mthcp_pkg::CH_MINUS);
    k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 11);
    repeat (k) q.push_back(8'(48 + $urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 1) begin
      q.push_back(mthcp_pkg::CH_COMMA);
      q.push_back(mthcp_pkg::CH_ZERO);
      q.push_back(mthcp_pkg::CH_X);
      repeat ($urandom_range(1, 10)) begin
        k = $urandom_range(0, 15);
        if (k < 10) q.push_back(8'(48 + k));
        else if ($urandom_range(0, 1) == 1) q.push_back(8'(55 + k));
        else q.push_back(8'(87 + k));
      end
    end
    if (q.size() == 0) q.push_back(8'(48 + $urandom_range(0, 9)));
    pos = $urandom_range(0, q.size() - 1);
    case ($urandom_range(0, 9))
      6: q[pos] = 8'($urandom_range(0, 255));
      7: begin
        case ($urandom_range(0, 7))
          0: q[pos] = mthcp_pkg::CH_COMMA;
          1: q[pos] = mthcp_pkg::CH_PLUS;
          2: q[pos] = mthcp_pkg::CH_MINUS;
          3: q[pos] = mthcp_pkg::CH_X;
          4: q[pos] = mthcp_pkg::CH_ZERO;
          5: q[pos] = 8'd103;
          6: q[pos] = 8'd71;
          default: q[pos] = 8'd32;
        endcase
      end
      8: if (q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
      9: begin
        q = {};
        repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  // Random tokens until the given number of further characters has been sent.
  task automatic test_random_tokens(input int chars);
    int      goal;
    char_q_t q;
    goal = live_chars + chars;
    while (live_chars < goal) begin
      build_token(q);
      send_token(q);
    end
  endtask

  // Result side stalls in random bursts while idling is on.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compares each result transfer with the oldest predicted token result.
  always @(posedge clk) begin : check_result
    mthcp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (token_results_q.size() == 0) begin
        report_mismatch("result transfer with no token pending");
      end else begin
        want = token_results_q.pop_front();
        if (result_data.height !== want.height)
          report_mismatch($sformatf("height got %0d want %0d",
                                    result_data.height, want.height));
        if (result_data.color !== want.color)
          report_mismatch($sformatf("color got %h want %h", result_data.color, want.color));
        if (result_data.has_color !== want.has_color)
          report_mismatch($sformatf("has_color got %b want %b",
                                    result_data.has_color, want.has_color));
        if (result_data.bad_token !== want.bad_token)
          report_mismatch($sformatf("bad_token got %b want %b",
                                    result_data.bad_token, want.bad_token));
      end
    end
  end

  initial begin
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_malformed();
    test_empty_height();
    test_random_tokens(520);
    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_tokens(140);
    char_valid <= 1'b0;
    wait_cycles = 0;
    while (token_results_q.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (token_results_q.size() != 0)
      report_mismatch($sformatf("%0d token results never arrived", token_results_q.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
